// ----- hw/rtl/ioct_pkg.sv -----
// Package for the in-order completion tracker.
// Holds the command, status, slot-state and controller state encodings.
// No dependencies.
`timescale 1ns / 1ps

package ioct_pkg;

    // Field widths of one item on either stream.
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 8;
    localparam int HANDLER_W = 4;
    localparam int ARG_W     = 32;
    localparam int DATA_W    = 80;  // 76 payload bits padded to whole bytes
    localparam int SSTATE_W  = 2;
    localparam int ENTRY_W   = HANDLER_W + 2 * ARG_W;

    // Command codes carried in the input tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_SIGNAL = 2'd1,
        CMD_RETIRE = 2'd2,
        CMD_RSVD   = 2'd3
    } t_cmd;

    // Status codes carried in the output tuser.
    typedef enum logic [STATUS_W-1:0] {
        RES_OK          = 2'd0,
        RES_BUSY        = 2'd1,
        RES_EMPTY       = 2'd2,
        RES_NOT_PENDING = 2'd3
    } t_status;

    // Per-slot state held in the state memory.
    typedef enum logic [SSTATE_W-1:0] {
        SLOT_FREE    = 2'd0,
        SLOT_PENDING = 2'd1,
        SLOT_DONE    = 2'd2
    } t_slot_state;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

// ----- hw/rtl/ioct_ram.sv -----
// Simple dual-port synchronous RAM with one write port and one read port.
// Read data is registered and holds while the read enable is low. No dependencies.
`timescale 1ns / 1ps

module ioct_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/in_order_completion_tracker.sv -----
// Top level of the in-order completion tracker: controller, pointers and result register.
// Depends on ioct_pkg and ioct_ram (slot-state memory and slot-entry memory).
//
// Channel  | Direction | tdata fields (low bit up)                     | tuser
// s_axis   | in        | slot_index, handler_id, arg_first, arg_second | command
// m_axis   | out       | out_slot, out_handler, out_first, out_second  | status
//
// Each item is handled in order: the slot memories are read when the idle state accepts
// it, then the update state updates the slot and loads the result register. The next
// item is accepted while a result still waits in the output. After reset a clearing
// pass marks every slot free; no item is accepted during it. An item whose result
// cannot be loaded waits in the update state.
`timescale 1ns / 1ps

module in_order_completion_tracker #(
    parameter int DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // slot_index[7:0], handler_id[11:8], arg_first[43:12], arg_second[75:44], zero pad
    input  logic [ioct_pkg::DATA_W-1:0] s_axis_tdata,
    // command[1:0]
    input  logic [ioct_pkg::CMD_W-1:0] s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // out_slot[7:0], out_handler[11:8], out_first[43:12], out_second[75:44], zero pad
    output logic [ioct_pkg::DATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [ioct_pkg::STATUS_W-1:0] m_axis_tuser
);

    import ioct_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    // Controller and pointer registers.
    t_state        r_state, n_state;
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [AW-1:0] r_clr_cnt, n_clr_cnt;
    logic          r_out_valid, n_out_valid;

    // Captured item and output payload.
    t_cmd                 r_cmd;
    logic [SLOT_W-1:0]    r_idx;
    logic [HANDLER_W-1:0] r_handler;
    logic [ARG_W-1:0]     r_first;
    logic [ARG_W-1:0]     r_second;
    logic [AW-1:0]        r_addr;
    logic                 r_in_range;
    t_status              r_out_status;
    logic [DATA_W-1:0]    r_out_data;

    // Memory interface.
    logic                st_we, st_re;
    logic [AW-1:0]       st_waddr, st_raddr;
    logic [SSTATE_W-1:0] st_wdata, st_rdata;
    logic                en_we, en_re;
    logic [ENTRY_W-1:0]  en_wdata, en_rdata;

    // Per-item combinational results.
    logic                 accept;
    logic                 can_finish;
    logic [AW-1:0]        acc_addr;
    t_status              res_status;
    logic [SLOT_W-1:0]    res_slot;
    logic [HANDLER_W-1:0] res_handler;
    logic [ARG_W-1:0]     res_first;
    logic [ARG_W-1:0]     res_second;

    ioct_ram #(
        .WIDTH (SSTATE_W),
        .DEPTH (DEPTH)
    ) u_state_mem (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    ioct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entry_mem (
        .i_clk   (i_clk),
        .i_we    (en_we),
        .i_waddr (r_wptr),
        .i_wdata (en_wdata),
        .i_re    (en_re),
        .i_raddr (r_rptr),
        .o_rdata (en_rdata)
    );

    // Handshakes and the slot each command looks at.
    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign can_finish    = !r_out_valid || m_axis_tready;

    always_comb begin
        case (t_cmd'(s_axis_tuser))
            CMD_ALLOC:  acc_addr = r_wptr;
            CMD_SIGNAL: acc_addr = AW'(s_axis_tdata[SLOT_W-1:0]);
            default:    acc_addr = r_rptr;
        endcase
    end

    assign st_re    = accept;
    assign st_raddr = acc_addr;
    assign en_re    = accept;
    assign en_wdata = {r_second, r_first, r_handler};

    // Next state, slot update and result of the item in flight.
    always_comb begin
        n_state     = r_state;
        n_wptr      = r_wptr;
        n_rptr      = r_rptr;
        n_clr_cnt   = r_clr_cnt;
        n_out_valid = r_out_valid && !m_axis_tready;
        st_we       = 1'b0;
        st_waddr    = r_addr;
        st_wdata    = SLOT_FREE;
        en_we       = 1'b0;
        res_status  = RES_NOT_PENDING;
        res_slot    = '0;
        res_handler = '0;
        res_first   = '0;
        res_second  = '0;

        unique case (r_cmd)
            CMD_ALLOC: begin
                res_slot = SLOT_W'(r_wptr);
                if (t_slot_state'(st_rdata) == SLOT_FREE) begin
                    res_status = RES_OK;
                end else begin
                    res_status = RES_BUSY;
                end
            end
            CMD_SIGNAL: begin
                res_slot = r_idx;
                if (r_in_range && t_slot_state'(st_rdata) == SLOT_PENDING) begin
                    res_status = RES_OK;
                end
            end
            CMD_RETIRE: begin
                res_slot = SLOT_W'(r_rptr);
                if (t_slot_state'(st_rdata) == SLOT_DONE) begin
                    res_status  = RES_OK;
                    res_handler = en_rdata[HANDLER_W-1:0];
                    res_first   = en_rdata[HANDLER_W +: ARG_W];
                    res_second  = en_rdata[HANDLER_W+ARG_W +: ARG_W];
                end else begin
                    res_status = RES_EMPTY;
                end
            end
            default: begin
                res_status = RES_NOT_PENDING;
            end
        endcase

        unique case (r_state)
            ST_CLEAR: begin
                st_we     = 1'b1;
                st_waddr  = r_clr_cnt;
                st_wdata  = SLOT_FREE;
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == LAST_SLOT) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (can_finish) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    if (res_status == RES_OK) begin
                        st_we = 1'b1;
                        unique case (r_cmd)
                            CMD_ALLOC: begin
                                st_wdata = SLOT_PENDING;
                                en_we    = 1'b1;
                                n_wptr   = (r_wptr == LAST_SLOT) ? '0 : r_wptr + 1'b1;
                            end
                            CMD_SIGNAL: begin
                                st_wdata = SLOT_DONE;
                            end
                            CMD_RETIRE: begin
                                st_wdata = SLOT_FREE;
                                n_rptr   = (r_rptr == LAST_SLOT) ? '0 : r_rptr + 1'b1;
                            end
                            default: begin
                                st_we = 1'b0;
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wptr      <= n_wptr;
            r_rptr      <= n_rptr;
            r_clr_cnt   <= n_clr_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the accepted item.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= t_cmd'(s_axis_tuser);
            r_idx      <= s_axis_tdata[SLOT_W-1:0];
            r_handler  <= s_axis_tdata[SLOT_W +: HANDLER_W];
            r_first    <= s_axis_tdata[SLOT_W+HANDLER_W +: ARG_W];
            r_second   <= s_axis_tdata[SLOT_W+HANDLER_W+ARG_W +: ARG_W];
            r_addr     <= acc_addr;
            r_in_range <= (32'(s_axis_tdata[SLOT_W-1:0]) < 32'(DEPTH));
        end
    end

    // Load the result register when the item completes.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXEC && can_finish) begin
            r_out_status <= res_status;
            r_out_data   <= DATA_W'({res_second, res_first, res_handler, res_slot});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

endmodule
